[rtl/mr4_pkg.sv]
// ----------------------------------------------------------------------------
// mr4_pkg
// Shared constants and types for the 4x4 fixed-point row multiplier.
// ----------------------------------------------------------------------------
package mr4_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DIM            = 4;
  localparam int ROW_W          = 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MUL  = 1'b1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

[rtl/matrix4_row_multiply.sv]
// ----------------------------------------------------------------------------
// matrix4_row_multiply
// Row-by-row 4x4 matrix multiply in signed fixed point.
// ----------------------------------------------------------------------------
// Both channels use a valid/ready handshake; one word moves on each edge at
// which valid and ready are both high. An input word with func load writes
// one row of the stored right-hand matrix and gives no result. A word with
// func multiply carries one left-hand row and gives one result word: the row
// index and four saturated dot products with the stored columns.
// A multiply word shows its result on the output port after passing the
// product registers, which load at the accepting edge, and then the
// combine, sum and output registers in that order.
// One word is taken per cycle while in_ready is high; loads and multiplies
// may be mixed freely; a multiply right after a load already sees the new row.
// Reset clears the stored matrix to zeros and empties the pipeline.
// When the receiver stalls, the pipeline fills up; bubbles are squeezed
// out, and in_ready falls only once every stage holds a result.
// ----------------------------------------------------------------------------
module matrix4_row_multiply #(
  parameter int ElemWidth = mr4_pkg::ELEM_WIDTH_DEF,
  parameter int FracBits  = mr4_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [mr4_pkg::ROW_W-1:0]     in_row_index,
  input  logic signed [ElemWidth-1:0]   in_elem0,
  input  logic signed [ElemWidth-1:0]   in_elem1,
  input  logic signed [ElemWidth-1:0]   in_elem2,
  input  logic signed [ElemWidth-1:0]   in_elem3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mr4_pkg::ROW_W-1:0]     out_row,
  output logic signed [ElemWidth-1:0]   out_prod0,
  output logic signed [ElemWidth-1:0]   out_prod1,
  output logic signed [ElemWidth-1:0]   out_prod2,
  output logic signed [ElemWidth-1:0]   out_prod3
);
  import mr4_pkg::*;

  logic [DIM-1:0][ElemWidth-1:0]          row_in;
  logic [DIM-1:0][DIM-1:0][ElemWidth-1:0] mat;
  logic [DIM-1:0][ElemWidth-1:0]          lane_res;
  logic [DIM-1:0][ElemWidth-1:0]          res_r;
  stage_en_t                              en;
  logic                                   en_out;
  logic                                   accept;
  logic                                   v1_r, v2_r, v3_r, out_valid_r;
  logic [ROW_W-1:0]                       row1_r, row2_r, row3_r, out_row_r;

  assign row_in = {in_elem3, in_elem2, in_elem1, in_elem0};

  assign en_out   = !out_valid_r || out_ready;
  assign en.s3    = !v3_r || en_out;
  assign en.s2    = !v2_r || en.s3;
  assign en.s1    = !v1_r || en.s2;
  assign in_ready = en.s1;
  assign accept   = in_valid && in_ready;

  mr4_mat #(
    .ElemWidth(ElemWidth)
  ) u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_func == FUNC_LOAD)),
    .wr_row  (in_row_index),
    .wr_data (row_in),
    .mat     (mat)
  );

  for (genvar c = 0; c < DIM; c++) begin : g_lane
    logic [DIM-1:0][ElemWidth-1:0] col;

    for (genvar k = 0; k < DIM; k++) begin : g_col
      assign col[k] = mat[k][c];
    end

    mr4_lane #(
      .ElemWidth(ElemWidth),
      .FracBits (FracBits)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .a   (row_in),
      .b   (col),
      .res (lane_res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_r <= accept && (in_func == FUNC_MUL);
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en.s3) begin
        v3_r <= v2_r;
      end
      if (en_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      row1_r <= in_row_index;
    end
    if (en.s2) begin
      row2_r <= row1_r;
    end
    if (en.s3) begin
      row3_r <= row2_r;
    end
    if (en_out) begin
      out_row_r <= row3_r;
      res_r     <= lane_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_prod0 = res_r[0];
  assign out_prod1 = res_r[1];
  assign out_prod2 = res_r[2];
  assign out_prod3 = res_r[3];

endmodule

[rtl/mr4_mat.sv]
// ----------------------------------------------------------------------------
// mr4_mat
// Stored right-hand matrix, written one row at a time and cleared at reset.
// ----------------------------------------------------------------------------
module mr4_mat #(
  parameter int ElemWidth = mr4_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 wr_en,
  input  logic [mr4_pkg::ROW_W-1:0]                            wr_row,
  input  logic [mr4_pkg::DIM-1:0][ElemWidth-1:0]               wr_data,
  output logic [mr4_pkg::DIM-1:0][mr4_pkg::DIM-1:0][ElemWidth-1:0] mat
);
  import mr4_pkg::*;

  logic [DIM-1:0][DIM-1:0][ElemWidth-1:0] mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (wr_en) begin
      mat_r[wr_row] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

[rtl/mr4_lane.sv]
// ----------------------------------------------------------------------------
// mr4_lane
// One result column: four split products, their sum, then scaling and
// saturation of the sum.
// ----------------------------------------------------------------------------
module mr4_lane #(
  parameter int ElemWidth = mr4_pkg::ELEM_WIDTH_DEF,
  parameter int FracBits  = mr4_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  mr4_pkg::stage_en_t                     en,
  input  logic [mr4_pkg::DIM-1:0][ElemWidth-1:0] a,
  input  logic [mr4_pkg::DIM-1:0][ElemWidth-1:0] b,
  output logic [ElemWidth-1:0]                   res
);
  import mr4_pkg::*;

  localparam int LoW  = ElemWidth / 2;
  localparam int HiW  = ElemWidth - LoW;
  localparam int PlW  = ElemWidth + LoW + 1;
  localparam int PhW  = ElemWidth + HiW;
  localparam int PrW  = 2 * ElemWidth;
  localparam int SumW = PrW + 2;

  logic signed [PlW-1:0]  pl_r   [DIM];
  logic signed [PhW-1:0]  ph_r   [DIM];
  logic signed [PrW-1:0]  prod_r [DIM];
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] shifted;
  logic [SumW-ElemWidth:0] upper;

  // The stored operand is split into an unsigned low half and a signed high
  // half so that each multiplier stays about half the full width.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIM; k++) begin
      if (en.s1) begin
        pl_r[k] <= PlW'($signed(a[k])) * PlW'($signed({1'b0, b[k][LoW-1:0]}));
        ph_r[k] <= PhW'($signed(a[k])) * PhW'($signed(b[k][ElemWidth-1:LoW]));
      end
      if (en.s2) begin
        prod_r[k] <= $signed({ph_r[k], {LoW{1'b0}}}) + PrW'(pl_r[k]);
      end
    end
    if (en.s3) begin
      sum_r <= SumW'(prod_r[0]) + SumW'(prod_r[1]) + SumW'(prod_r[2]) + SumW'(prod_r[3]);
    end
  end

  always_comb begin
    shifted = sum_r >>> FracBits;
    upper   = shifted[SumW-1:ElemWidth-1];
    if ((&upper) || !(|upper)) begin
      res = shifted[ElemWidth-1:0];
    end else if (shifted[SumW-1]) begin
      res = {1'b1, {(ElemWidth-1){1'b0}}};
    end else begin
      res = {1'b0, {(ElemWidth-1){1'b1}}};
    end
  end

endmodule
